@@ hdl/dest_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dest_pkg
// Shared types and constants for the entry set table: request and response
// payloads, stored entry layout, controller commands and status, and states.
// ----------------------------------------------------------------------------
package dest_pkg;

  localparam int CAPACITY   = 256;
  localparam int LAYER_BITS = 4;

  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int SLOT_W     = 8;
  localparam int LIVE_W     = 9;
  localparam int LAYER_IN_W = 4;
  localparam int LAYER_KEEP = (LAYER_BITS < LAYER_IN_W) ? LAYER_BITS : LAYER_IN_W;
  localparam int CMP_W      = (COUNT_W > SLOT_W) ? COUNT_W : SLOT_W;

  localparam logic [2:0] REQ_CLEAR        = 3'd0;
  localparam logic [2:0] REQ_ADD          = 3'd1;
  localparam logic [2:0] REQ_REMOVE_KEY   = 3'd2;
  localparam logic [2:0] REQ_REMOVE_INDEX = 3'd3;
  localparam logic [2:0] REQ_CONTAINS     = 3'd4;
  localparam logic [2:0] REQ_GET          = 3'd5;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [31:0]      pos_x;
    logic signed [31:0]      pos_y;
    logic [LAYER_IN_W-1:0]   layer;
    logic [SLOT_W-1:0]       slot;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [31:0]      out_x;
    logic signed [31:0]      out_y;
    logic [LAYER_IN_W-1:0]   out_layer;
    logic [LIVE_W-1:0]       live_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0]             x;
    logic [31:0]             y;
    logic [LAYER_KEEP-1:0]   layer;
  } entry_t;

  typedef struct packed {
    logic load_req;
    logic clr_count;
    logic scan_step;
    logic rd_last;
    logic rd_slot;
    logic set_target_hit;
    logic set_target_slot;
    logic move_write;
    logic add_write;
    logic res_ok;
    logic res_get;
    logic out_load;
  } dest_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       slot_lt_count;
    logic       full;
    logic       hit;
    logic       scan_done;
    logic       out_free;
  } dest_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_GET_RD,
    ST_GET_DATA,
    ST_FINISH
  } dest_state_t;

endpackage

@@ hdl/dest_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dest_ctrl
// Request sequencer: decodes each accepted request and steps the datapath
// through scan, move, fetch and response phases.
// ----------------------------------------------------------------------------
module dest_ctrl
  import dest_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  dest_status_t status,
  output dest_cmd_t    cmd
);

  dest_state_t state;
  dest_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.req_type)
          REQ_ADD, REQ_REMOVE_KEY, REQ_CONTAINS: state_next = ST_SCAN;
          REQ_REMOVE_INDEX: state_next = status.slot_lt_count ? ST_MOVE_RD : ST_FINISH;
          REQ_GET: state_next = status.slot_lt_count ? ST_GET_RD : ST_FINISH;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        if (status.hit) begin
          state_next = (status.req_type == REQ_REMOVE_KEY) ? ST_MOVE_RD : ST_FINISH;
        end else if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_MOVE_RD:  state_next = ST_MOVE_WR;
      ST_MOVE_WR:  state_next = ST_FINISH;
      ST_GET_RD:   state_next = ST_GET_DATA;
      ST_GET_DATA: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      ST_DECODE: begin
        unique case (status.req_type)
          REQ_CLEAR: begin
            cmd.clr_count = 1'b1;
            cmd.res_ok    = 1'b1;
          end
          REQ_REMOVE_INDEX: cmd.set_target_slot = status.slot_lt_count;
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (status.hit) begin
          cmd.res_ok         = (status.req_type != REQ_REMOVE_KEY);
          cmd.set_target_hit = (status.req_type == REQ_REMOVE_KEY);
        end else if (status.scan_done) begin
          cmd.add_write = (status.req_type == REQ_ADD) && !status.full;
          cmd.res_ok    = (status.req_type == REQ_ADD) && !status.full;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MOVE_RD: cmd.rd_last = 1'b1;
      ST_MOVE_WR: begin
        cmd.move_write = 1'b1;
        cmd.res_ok     = 1'b1;
      end
      ST_GET_RD:   cmd.rd_slot = 1'b1;
      ST_GET_DATA: cmd.res_get = 1'b1;
      ST_FINISH:   cmd.out_load = status.out_free;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_DECODE)
    else $error("accepted request did not enter decode");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && !status.out_free |=> state == ST_FINISH)
    else $error("response dropped while output busy");

  a_move_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_MOVE_RD |=> state == ST_MOVE_WR)
    else $error("move read not followed by move write");
`endif

endmodule

@@ hdl/dest_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dest_datapath
// Entry memory, live count, scan counter, key compare, result registers and
// the response output register.
// ----------------------------------------------------------------------------
module dest_datapath
  import dest_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  req_t         req,
  input  dest_cmd_t    cmd,
  output dest_status_t status,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output rsp_t         rsp
);

  entry_t mem [CAPACITY];

  req_t                req_q;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  scan_idx;
  logic [ADDR_W-1:0]   target;
  logic [ADDR_W-1:0]   rd_idx;
  logic                rd_pend;
  entry_t              rd_data;
  logic                res_ok;
  entry_t              res_entry;

  entry_t              key;
  logic                scan_more;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic [COUNT_W-1:0]  last_idx;

  assign key.x     = req_q.pos_x;
  assign key.y     = req_q.pos_y;
  assign key.layer = LAYER_KEEP'(req_q.layer);

  assign scan_more = scan_idx < count;
  assign last_idx  = count - COUNT_W'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx[ADDR_W-1:0];
    if (cmd.scan_step && scan_more) begin
      rd_en = 1'b1;
    end else if (cmd.rd_last) begin
      rd_en   = 1'b1;
      rd_addr = last_idx[ADDR_W-1:0];
    end else if (cmd.rd_slot) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(req_q.slot);
    end
  end

  always_comb begin
    wr_en   = cmd.add_write || cmd.move_write;
    wr_addr = target;
    wr_data = rd_data;
    if (cmd.add_write) begin
      wr_addr = count[ADDR_W-1:0];
      wr_data = key;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count <= '0;
      end else if (cmd.add_write) begin
        count <= count + COUNT_W'(1);
      end else if (cmd.move_write) begin
        count <= last_idx;
      end
      rd_pend <= cmd.scan_step && scan_more;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q     <= req;
      scan_idx  <= '0;
      res_ok    <= 1'b0;
      res_entry <= '0;
    end else begin
      if (cmd.scan_step && scan_more) begin
        scan_idx <= scan_idx + COUNT_W'(1);
      end
      if (cmd.res_ok) begin
        res_ok <= 1'b1;
      end
      if (cmd.res_get) begin
        res_ok    <= 1'b1;
        res_entry <= rd_data;
      end
    end
    if (cmd.set_target_slot) begin
      target <= ADDR_W'(req_q.slot);
    end else if (cmd.set_target_hit) begin
      target <= rd_idx;
    end
    if (cmd.out_load) begin
      rsp.ok         <= res_ok;
      rsp.out_x      <= res_entry.x;
      rsp.out_y      <= res_entry.y;
      rsp.out_layer  <= LAYER_IN_W'(res_entry.layer);
      rsp.live_count <= LIVE_W'(count);
    end
  end

  assign status.req_type      = req_q.req_type;
  assign status.slot_lt_count = CMP_W'(req_q.slot) < CMP_W'(count);
  assign status.full          = count == COUNT_W'(CAPACITY);
  assign status.hit           = rd_pend && (rd_data == key);
  assign status.scan_done     = !rd_pend && !scan_more;
  assign status.out_free      = !rsp_valid || rsp_ready;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("live count exceeds capacity");

  a_add_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write |-> count < COUNT_W'(CAPACITY))
    else $error("add written into a full table");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.move_write |-> count != '0 && COUNT_W'(target) < count)
    else $error("swap remove outside the live entries");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !cmd.out_load)
    else $error("response overwritten before transfer");
`endif

endmodule

@@ hdl/dedup_entry_set_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_entry_set_table
// Bounded set of position and layer keys with swap-remove, built as a
// request sequencer and a datapath around a single entry memory.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. Add, remove by key and contains scan the
// live entries through the one read port of the entry memory, one entry per
// cycle, until a hit or the end of the live entries. Remove by slot refills
// the freed slot by reading the last entry and writing it back into the slot.
// A finished response waits in an output register, and the next request is
// accepted while it waits for its transfer; a request that finishes while
// that register is still full holds until the transfer.
// ----------------------------------------------------------------------------
module dedup_entry_set_table
  import dest_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  dest_cmd_t    cmd;
  dest_status_t status;

  dest_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dest_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ tb/dedup_entry_set_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_entry_set_table_test
// Self-checking bench for the bounded key set with swap-remove. A table of
// directed requests covers the empty, duplicate, out-of-range, unused-code and
// clear cases. Random traffic follows, including one pass that fills the set
// to capacity. Responses are checked against the table's expected values or a
// local model of the set; both sides idle at random except in the fill pass.
// ----------------------------------------------------------------------------
module dedup_entry_set_table_test;
  import dest_pkg::*;

  localparam logic [2:0]  REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0]  REQ_UNUSED_7 = 3'd7;
  localparam logic [31:0] POS_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] POS_MIN      = 32'h8000_0000;
  localparam logic [31:0] POS_NEG1     = 32'hffff_ffff;
  localparam logic [3:0]  LAYER_MASK   = 4'((1 << LAYER_KEEP) - 1);
  localparam int          POOL_SIZE    = 16;
  localparam int          QUIET_LIMIT  = 5000;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [31:0] set_x     [CAPACITY];
  logic [31:0] set_y     [CAPACITY];
  logic [3:0]  set_layer [CAPACITY];
  int          set_count;
  int          peak_count;
  int          full_rejects;

  logic [31:0] pool_x     [POOL_SIZE];
  logic [31:0] pool_y     [POOL_SIZE];
  logic [3:0]  pool_layer [POOL_SIZE];

  rsp_t        owed_rsp [$];
  rsp_t        head_rsp;
  plan_row_t   plan [$];
  int          stall_pct = 33;
  int          sent;
  int          checked;
  int          mismatches;
  int          quiet;

  dedup_entry_set_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_slot(logic [31:0] x, logic [31:0] y, logic [3:0] lay);
    for (int i = 0; i < set_count; i++) begin
      if (set_x[i] == x && set_y[i] == y && set_layer[i] == (lay & LAYER_MASK)) return i;
    end
    return set_count;
  endfunction

  function automatic void drop_slot(int s);
    set_x[s]     = set_x[set_count - 1];
    set_y[s]     = set_y[set_count - 1];
    set_layer[s] = set_layer[set_count - 1];
    set_count--;
  endfunction

  function automatic rsp_t table_response(req_t r);
    rsp_t o;
    int   hit;
    o   = '0;
    hit = find_slot(r.pos_x, r.pos_y, r.layer);
    case (r.req_type)
      REQ_CLEAR: begin
        set_count = 0;
        o.ok      = 1'b1;
      end
      REQ_ADD: begin
        if (hit < set_count) begin
          o.ok = 1'b1;
        end else if (set_count < CAPACITY) begin
          set_x[set_count]     = r.pos_x;
          set_y[set_count]     = r.pos_y;
          set_layer[set_count] = r.layer & LAYER_MASK;
          set_count++;
          o.ok = 1'b1;
        end else begin
          full_rejects++;
        end
      end
      REQ_REMOVE_KEY: begin
        if (hit < set_count) begin
          drop_slot(hit);
          o.ok = 1'b1;
        end
      end
      REQ_REMOVE_INDEX: begin
        if (r.slot < set_count) begin
          drop_slot(int'(r.slot));
          o.ok = 1'b1;
        end
      end
      REQ_CONTAINS: begin
        o.ok = (hit < set_count);
      end
      REQ_GET: begin
        if (r.slot < set_count) begin
          o.out_x     = set_x[r.slot];
          o.out_y     = set_y[r.slot];
          o.out_layer = set_layer[r.slot];
          o.ok        = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.live_count = LIVE_W'(set_count);
    if (set_count > peak_count) peak_count = set_count;
    return o;
  endfunction

  function automatic plan_row_t step_row(logic [2:0] op, logic [31:0] x, logic [31:0] y,
                                         int lay, logic [7:0] s, int typed,
                                         int ok, logic [31:0] ex, logic [31:0] ey,
                                         int el, logic [8:0] cnt);
    plan_row_t row;
    row.r.req_type       = op;
    row.r.pos_x          = x;
    row.r.pos_y          = y;
    row.r.layer          = LAYER_IN_W'(lay);
    row.r.slot           = s;
    row.typed            = (typed != 0);
    row.want.ok          = (ok != 0);
    row.want.out_x       = ex;
    row.want.out_y       = ey;
    row.want.out_layer   = LAYER_IN_W'(el);
    row.want.live_count  = cnt;
    return row;
  endfunction

  function automatic req_t pick_req();
    req_t r;
    int   roll;
    int   k;
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.layer = LAYER_IN_W'($urandom);
    r.slot  = SLOT_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 50) begin
      k       = $urandom_range(POOL_SIZE - 1);
      r.pos_x = pool_x[k];
      r.pos_y = pool_y[k];
      r.layer = pool_layer[k];
    end else if (roll < 80 && set_count > 0) begin
      k       = $urandom_range(set_count - 1);
      r.pos_x = set_x[k];
      r.pos_y = set_y[k];
      r.layer = set_layer[k];
    end
    if (set_count > 0 && $urandom_range(99) < 75) begin
      r.slot = SLOT_W'($urandom_range(set_count - 1));
    end
    roll = $urandom_range(99);
    if (roll < 2)       r.req_type = REQ_CLEAR;
    else if (roll < 32) r.req_type = REQ_ADD;
    else if (roll < 47) r.req_type = REQ_REMOVE_KEY;
    else if (roll < 57) r.req_type = REQ_REMOVE_INDEX;
    else if (roll < 72) r.req_type = REQ_CONTAINS;
    else if (roll < 95) r.req_type = REQ_GET;
    else if (roll < 97) r.req_type = REQ_UNUSED_6;
    else                r.req_type = REQ_UNUSED_7;
    return r;
  endfunction

  task automatic send_req(req_t item, bit typed, rsp_t typed_rsp);
    rsp_t want;
    while ($urandom_range(99) < stall_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = table_response(item);
    if (typed) want = typed_rsp;
    owed_rsp.push_back(want);
    sent++;
  endtask

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_rsp.size() == 0) begin
        if (mismatches < 10) $display("%0t: response with nothing outstanding: %p", $time, rsp);
        mismatches++;
      end else begin
        head_rsp = owed_rsp.pop_front();
        checked++;
        if (rsp.ok !== head_rsp.ok || rsp.out_x !== head_rsp.out_x ||
            rsp.out_y !== head_rsp.out_y || rsp.out_layer !== head_rsp.out_layer ||
            rsp.live_count !== head_rsp.live_count) begin
          if (mismatches < 10) begin
            $display("%0t: response %0d expected ok=%0b x=%0d y=%0d layer=%0d count=%0d",
                     $time, checked, head_rsp.ok, head_rsp.out_x, head_rsp.out_y,
                     head_rsp.out_layer, head_rsp.live_count);
            $display("%0t: response %0d actual   ok=%0b x=%0d y=%0d layer=%0d count=%0d",
                     $time, checked, rsp.ok, rsp.out_x, rsp.out_y, rsp.out_layer,
                     rsp.live_count);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    req_t r;
    rsp_t none;
    none = '0;

    pool_x[0] = POS_MAX;  pool_y[0] = POS_MIN;  pool_layer[0] = 4'd15;
    pool_x[1] = POS_MIN;  pool_y[1] = POS_MAX;  pool_layer[1] = 4'd0;
    pool_x[2] = POS_NEG1; pool_y[2] = POS_NEG1; pool_layer[2] = 4'd10;
    pool_x[3] = '0;       pool_y[3] = '0;       pool_layer[3] = 4'd5;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_x[i]     = $urandom;
      pool_y[i]     = $urandom;
      pool_layer[i] = 4'($urandom) & LAYER_MASK;
    end

    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd0, 1, 0, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_REMOVE_INDEX, 0, 0, 0, 8'd0, 1, 0, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_REMOVE_KEY, 1, 2, 3, 8'd0, 1, 0, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_CONTAINS, 1, 2, 3, 8'd0, 1, 0, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_ADD, POS_MAX, POS_MIN, 15, 8'd0, 1, 1, 0, 0, 0, 9'd1));
    plan.push_back(step_row(REQ_ADD, POS_MAX, POS_MIN, 15, 8'd0, 1, 1, 0, 0, 0, 9'd1));
    plan.push_back(step_row(REQ_ADD, POS_MIN, POS_MAX, 0, 8'd255, 1, 1, 0, 0, 0, 9'd2));
    plan.push_back(step_row(REQ_ADD, 0, 0, 5, 8'd0, 1, 1, 0, 0, 0, 9'd3));
    plan.push_back(step_row(REQ_ADD, POS_NEG1, POS_NEG1, 10, 8'd0, 1, 1, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_CONTAINS, POS_MAX, POS_MIN, 15, 8'd0, 1, 1, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_CONTAINS, POS_MAX, POS_MIN, 14, 8'd0, 1, 0, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd0, 1, 1, POS_MAX, POS_MIN, 15, 9'd4));
    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd255, 1, 0, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd4, 1, 0, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_UNUSED_6, POS_MAX, POS_MIN, 15, 8'd0, 1, 0, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_UNUSED_7, POS_NEG1, 0, 10, 8'd1, 1, 0, 0, 0, 0, 9'd4));
    plan.push_back(step_row(REQ_REMOVE_KEY, POS_MAX, POS_MIN, 15, 8'd0, 1, 1, 0, 0, 0, 9'd3));
    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd0, 0, 0, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_REMOVE_INDEX, 0, 0, 0, 8'd3, 1, 0, 0, 0, 0, 9'd3));
    plan.push_back(step_row(REQ_REMOVE_INDEX, 0, 0, 0, 8'd2, 1, 1, 0, 0, 0, 9'd2));
    plan.push_back(step_row(REQ_REMOVE_INDEX, 0, 0, 0, 8'd0, 1, 1, 0, 0, 0, 9'd1));
    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd0, 0, 0, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_CLEAR, POS_NEG1, POS_NEG1, 15, 8'd255, 1, 1, 0, 0, 0, 9'd0));
    plan.push_back(step_row(REQ_GET, 0, 0, 0, 8'd0, 1, 0, 0, 0, 0, 9'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_req(plan[i].r, plan[i].typed, plan[i].want);

    for (int i = 0; i < 160; i++) send_req(pick_req(), 0, none);

    req_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);

    // Fill to capacity with no idling on either side, then work at the limit.
    stall_pct = 0;
    r = '0;
    r.req_type = REQ_CLEAR;
    send_req(r, 0, none);
    for (int i = 0; i < CAPACITY; i++) begin
      r.req_type = REQ_ADD;
      r.pos_x    = $urandom;
      r.pos_y    = ($urandom & 32'hffff_ff00) | i;
      r.layer    = LAYER_IN_W'($urandom);
      r.slot     = SLOT_W'($urandom);
      send_req(r, 0, none);
    end
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    send_req(r, 0, none);
    r.req_type = REQ_GET;
    r.slot     = 8'd255;
    send_req(r, 0, none);
    for (int i = 0; i < 24; i++) send_req(pick_req(), 0, none);
    stall_pct = 33;

    for (int i = 0; i < 100; i++) send_req(pick_req(), 0, none);

    req_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (CAPACITY + 40) @(posedge clk);
    if (owed_rsp.size() != 0) mismatches++;

    $display("Sent %0d requests and checked %0d responses; the set peaked at %0d of %0d",
             sent, checked, peak_count, CAPACITY);
    $display("entries, and %0d adds were refused on a full set.", full_rejects);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dest_pkg.sv
hdl/dest_ctrl.sv
hdl/dest_datapath.sv
hdl/dedup_entry_set_table.sv
tb/dedup_entry_set_table_test.sv
